>>> hw/rtl/slxfp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package slxfp_pkg;

    localparam logic [7:0] HDR0_BYTE  = 8'h55;
    localparam logic [7:0] HDR1_BYTE  = 8'h4E;
    localparam logic [7:0] HDR2_BYTE  = 8'h45;
    localparam logic [7:0] HDR3_BYTE  = 8'h52;
    localparam logic [7:0] TOKEN_BYTE = 8'h3A;

    localparam int SAMPLE_COUNT = 12;
    localparam int SENSOR_COUNT = SAMPLE_COUNT / 2;

    localparam logic [15:0] TIMEOUT_RESET = 16'd100;
    localparam logic [7:0]  SENSOR_RESET  = 8'hC0;
    localparam logic [7:0]  ALIVE_RESET   = 8'hF0;

    // configuration register indexes
    localparam logic [1:0] CFG_TIMEOUT = 2'd0;
    localparam logic [1:0] CFG_SENSOR  = 2'd1;
    localparam logic [1:0] CFG_ALIVE   = 2'd2;

    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_HDR1  = 3'd1,
        PH_HDR2  = 3'd2,
        PH_HDR3  = 3'd3,
        PH_LEN   = 3'd4,
        PH_TOKEN = 3'd5,
        PH_CMD   = 3'd6,
        PH_BODY  = 3'd7
    } phase_t;

    typedef enum logic [2:0] {
        ST_SENSOR_OK = 3'd0,
        ST_ALIVE     = 3'd1,
        ST_UNKNOWN   = 3'd2,
        ST_CSUM_ERR  = 3'd3,
        ST_SHORT     = 3'd4
    } status_t;

    typedef struct packed {
        logic [15:0] timeout_ticks;
        logic [7:0]  sensor_command;
        logic [7:0]  alive_command;
    } cfg_t;

    typedef struct packed {
        logic [SENSOR_COUNT-1:0][15:0] sensors;   // sensor_f in the top slot
        logic [7:0]                    command_code;
        status_t                       status;
    } res_t;

endpackage

`default_nettype wire

>>> hw/rtl/slxfp_parser.sv
`timescale 1ns / 1ps
`default_nettype none

module slxfp_parser (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           step_en,
    input  wire logic           action,
    input  wire logic [7:0]     data_byte,
    input  wire slxfp_pkg::cfg_t cfg,
    output logic                res_valid,
    output slxfp_pkg::res_t     res
);
    import slxfp_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [7:0]  length_reg, length_next;
    logic [7:0]  command_reg, command_next;
    logic [7:0]  count_reg, count_next;
    logic [7:0]  xor_reg, xor_next;
    logic [15:0] tick_reg, tick_next;
    logic        armed_reg, armed_next;
    logic [7:0]  sample_reg [SAMPLE_COUNT];

    logic [15:0] tick_inc;
    logic        tick_hit;
    logic        in_payload;
    logic        sample_we;
    logic [3:0]  sample_idx;
    logic        csum_ok;
    logic        is_byte;

    assign is_byte    = (action == ACT_BYTE);
    assign tick_inc   = tick_reg + 16'd1;
    assign tick_hit   = (tick_inc >= cfg.timeout_ticks);
    assign in_payload = (count_reg < length_reg);
    assign csum_ok    = (data_byte == xor_reg);
    assign sample_idx = 4'(count_reg - 8'd1);
    assign sample_we  = step_en && is_byte && (phase_reg == PH_BODY) && in_payload
                        && (count_reg >= 8'd1) && (count_reg <= 8'(SAMPLE_COUNT));

    // next state
    always_comb begin
        phase_next = phase_reg;
        if (!is_byte) begin
            if (armed_reg && tick_hit) begin
                phase_next = PH_IDLE;
            end
        end else begin
            unique case (phase_reg)
                PH_IDLE:  phase_next = (data_byte == HDR0_BYTE) ? PH_HDR1 : PH_IDLE;
                PH_HDR1:  phase_next = (data_byte == HDR1_BYTE) ? PH_HDR2 : PH_IDLE;
                PH_HDR2:  phase_next = (data_byte == HDR2_BYTE) ? PH_HDR3 : PH_IDLE;
                PH_HDR3:  phase_next = (data_byte == HDR3_BYTE) ? PH_LEN : PH_IDLE;
                PH_LEN:   phase_next = PH_TOKEN;
                PH_TOKEN: phase_next = (data_byte == TOKEN_BYTE) ? PH_CMD : PH_IDLE;
                PH_CMD:   phase_next = PH_BODY;
                PH_BODY:  phase_next = in_payload ? PH_BODY : PH_IDLE;
                default:  phase_next = PH_IDLE;
            endcase
        end
    end

    // datapath and result
    always_comb begin
        length_next  = length_reg;
        command_next = command_reg;
        count_next   = count_reg;
        xor_next     = xor_reg;
        tick_next    = tick_reg;
        armed_next   = armed_reg;
        res_valid    = 1'b0;
        res.status       = ST_UNKNOWN;
        res.command_code = command_reg;
        res.sensors      = '0;

        if (!is_byte) begin
            if (armed_reg) begin
                tick_next = tick_inc;
                if (tick_hit) begin
                    armed_next = 1'b0;
                end
            end
        end else begin
            unique case (phase_reg) inside
                PH_IDLE: begin
                    if (data_byte == HDR0_BYTE) begin
                        xor_next   = data_byte;
                        tick_next  = '0;
                        armed_next = 1'b1;
                    end
                end
                PH_HDR1, PH_HDR2, PH_HDR3, PH_TOKEN: begin
                    if (phase_next == PH_IDLE) begin
                        armed_next = 1'b0;
                    end else begin
                        xor_next = xor_reg ^ data_byte;
                    end
                end
                PH_LEN: begin
                    length_next = data_byte;
                    xor_next    = xor_reg ^ data_byte;
                end
                PH_CMD: begin
                    command_next = data_byte;
                    xor_next     = xor_reg ^ data_byte;
                    count_next   = '0;
                end
                PH_BODY: begin
                    if (in_payload) begin
                        xor_next   = xor_reg ^ data_byte;
                        count_next = count_reg + 8'd1;
                    end else begin
                        // checksum beat closes the frame
                        armed_next = 1'b0;
                        res_valid  = 1'b1;
                        if (!csum_ok) begin
                            res.status = ST_CSUM_ERR;
                        end else if (command_reg == cfg.sensor_command) begin
                            if (length_reg >= 8'(SAMPLE_COUNT + 1)) begin
                                res.status = ST_SENSOR_OK;
                                for (int k = 0; k < SENSOR_COUNT; k++) begin
                                    res.sensors[k] = {sample_reg[2*k+1], sample_reg[2*k]};
                                end
                            end else begin
                                res.status = ST_SHORT;
                            end
                        end else if (command_reg == cfg.alive_command) begin
                            res.status = ST_ALIVE;
                        end else begin
                            res.status = ST_UNKNOWN;
                        end
                    end
                end
                default: armed_next = 1'b0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            length_reg  <= '0;
            command_reg <= '0;
            count_reg   <= '0;
            xor_reg     <= '0;
            tick_reg    <= '0;
            armed_reg   <= 1'b0;
        end else if (step_en) begin
            phase_reg   <= phase_next;
            length_reg  <= length_next;
            command_reg <= command_next;
            count_reg   <= count_next;
            xor_reg     <= xor_next;
            tick_reg    <= tick_next;
            armed_reg   <= armed_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (sample_we) begin
            sample_reg[sample_idx] <= data_byte;
        end
    end

`ifndef ASSERT_OFF
    // the timer runs exactly while a frame is open
    a_armed_open: assert property (@(posedge aclk) disable iff (!aresetn)
        armed_reg == (phase_reg != PH_IDLE))
        else $error("timer armed state disagrees with frame phase");

    a_res_body: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> (phase_reg == PH_BODY) && is_byte && !in_payload)
        else $error("result outside the checksum beat");

    a_res_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && res_valid |=> (phase_reg == PH_IDLE))
        else $error("parser did not return to idle after a frame");

    a_sensor_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && (res.status != ST_SENSOR_OK) |-> (res.sensors == '0))
        else $error("sensor values leaked on a non-sensor result");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_BODY) |-> (count_reg <= length_reg))
        else $error("payload count ran past the frame length");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/sync_length_xor_frame_parser_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// channel  | handshake          | tdata                               | tuser
// ---------+--------------------+-------------------------------------+----------
// s_ in    | s_tvalid/s_tready  | data_byte                           | action
// m_ out   | m_tvalid/m_tready  | command_code, sensor_a .. sensor_f  | status
// cfg      | cfg_wr_en          | cfg_addr selects, cfg_wdata value   | -
//
// one beat per cycle sustained unless the result register stalls
// the rate is set by the single parser stage between the input and result registers
// aresetn is synchronous; it clears control state and restores register defaults
// a stalled result register halts the parser; s_tready drops once the input register is full and the parser is halted

module sync_length_xor_frame_parser_unit (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [7:0]   s_tdata,   // data_byte
    input  wire logic         s_tuser,   // action
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [103:0]      m_tdata,   // command_code, sensor_a .. sensor_f
    output logic [2:0]        m_tuser,   // status
    input  wire logic         cfg_wr_en,
    input  wire logic [1:0]   cfg_addr,
    input  wire logic [15:0]  cfg_wdata
);
    import slxfp_pkg::*;

    cfg_t       cfg_reg;
    logic       in_valid_reg;
    logic       in_action_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;
    res_t       out_reg;

    logic step_en;
    logic res_valid;
    res_t res;

    assign step_en  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.timeout_ticks  <= TIMEOUT_RESET;
            cfg_reg.sensor_command <= SENSOR_RESET;
            cfg_reg.alive_command  <= ALIVE_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_TIMEOUT: cfg_reg.timeout_ticks  <= cfg_wdata;
                CFG_SENSOR:  cfg_reg.sensor_command <= cfg_wdata[7:0];
                CFG_ALIVE:   cfg_reg.alive_command  <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_action_reg <= s_tuser;
            in_byte_reg   <= s_tdata;
        end
    end

    slxfp_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (step_en),
        .action    (in_action_reg),
        .data_byte (in_byte_reg),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step_en) begin
            out_valid_reg <= res_valid;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {out_reg.sensors, out_reg.command_code};

endmodule

`default_nettype wire
